// ===== hdl/gocu_pkg.sv =====
// Package for the grouped ordered row cache: sizes, status and operation codes, stream item and row types.
// Used by the top level, the front and back ends and the testbench; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package gocu_pkg;
  localparam int GROUPS = 16;
  localparam int GRP_W = $clog2(GROUPS);
  localparam int ROWS = 8;
  localparam int ROW_W = $clog2(ROWS);
  localparam int CNT_W = $clog2(ROWS + 1);
  localparam int KEY_W = 64;
  localparam int HND_W = 16;
  localparam int WANT_W = 4;
  localparam int LIM_W = 4;
  localparam int IN_W = 152;
  localparam int OUT_W = 40;
  localparam int QDEPTH = 2;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_MISS = 2'd2;

  localparam logic OP_CACHE = 1'b0;
  localparam logic OP_LIST = 1'b1;

  typedef struct packed {
    logic is_list;
    logic [KEY_W-1:0] grp_key;
    logic [KEY_W-1:0] order_key;
    logic [HND_W-1:0] row_handle;
    logic [WANT_W-1:0] want_count;
  } item_t;

  typedef struct packed {
    logic [KEY_W-1:0] order_key;
    logic [HND_W-1:0] handle;
  } row_t;
endpackage
`default_nettype wire

// ===== hdl/grouped_ordered_row_cache_unit.sv =====
// Top level of the grouped ordered row cache: configuration register, front and back ends.
// Depends on gocu_pkg, gocu_front and gocu_back.
// One item at a time in the back end; the memory port moves one row per cycle, and a stalled output holds the back end.
// Reset clears the group valid bits, the queue and the output; keep_limit becomes 2.
`timescale 1ns / 1ps
`default_nettype none
module grouped_ordered_row_cache_unit (
  input  wire logic clk,
  input  wire logic rst,
  // Input stream. tdata: grp_key[63:0], order_key[127:64], row_handle[143:128],
  // want_count[147:144], zero fill up to bit 151.
  input  wire logic s_tvalid,
  output logic s_tready,
  input  wire logic [gocu_pkg::IN_W-1:0] s_tdata,
  // tuser: operation (0 cache a row, 1 list newest rows).
  input  wire logic s_tuser,
  // Result stream. tdata: status[1:0], row_valid[2], row_out[18:3], evicted[19],
  // evicted_handle[35:20], zero fill up to bit 39.
  output logic m_tvalid,
  input  wire logic m_tready,
  output logic [gocu_pkg::OUT_W-1:0] m_tdata,
  // tlast: final result transfer of one input item.
  output logic m_tlast,
  // Configuration port; keep_limit sits at address 0.
  input  wire logic psel,
  input  wire logic penable,
  input  wire logic pwrite,
  input  wire logic [2:0] paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready
);
  logic [gocu_pkg::LIM_W-1:0] keep_limit;
  logic q_valid;
  logic q_pop;
  gocu_pkg::item_t q_item;

  assign pready = 1'b1;
  // keep_limit answers at addresses 0 to 3 (paddr[2] low); addresses 4 to 7 read as zero and ignore writes.
  assign prdata = (paddr[2] == 1'b0) ? {28'd0, keep_limit} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      keep_limit <= 4'd2;
    end else if (psel && penable && pwrite && pready && paddr[2] == 1'b0) begin
      keep_limit <= pwdata[gocu_pkg::LIM_W-1:0];
    end
  end

  // The front end keeps accepting into its two-entry queue while the back end is busy, until the queue is full.
  gocu_front u_front (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .q_valid(q_valid),
    .q_item(q_item),
    .q_pop(q_pop)
  );

  // The back end owns the group table, the row memory and the output register.
  gocu_back u_back (
    .clk(clk),
    .rst(rst),
    .keep_limit(keep_limit),
    .q_valid(q_valid),
    .q_item(q_item),
    .q_pop(q_pop),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tlast(m_tlast)
  );
endmodule
`default_nettype wire

// ===== hdl/gocu_front.sv =====
// Front end: accepts stream transfers, unpacks and classifies them, and queues them.
// Depends on gocu_pkg.
`timescale 1ns / 1ps
`default_nettype none
module gocu_front (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic s_tvalid,
  output logic s_tready,
  input  wire logic [gocu_pkg::IN_W-1:0] s_tdata,
  input  wire logic s_tuser,
  output logic q_valid,
  output gocu_pkg::item_t q_item,
  input  wire logic q_pop
);
  gocu_pkg::item_t slots [gocu_pkg::QDEPTH];
  logic [1:0] fill;
  logic wr_ptr;
  logic rd_ptr;
  gocu_pkg::item_t in_item;
  logic push;

  always_comb begin
    in_item.is_list = (s_tuser == gocu_pkg::OP_LIST);
    in_item.grp_key = s_tdata[63:0];
    in_item.order_key = s_tdata[127:64];
    in_item.row_handle = s_tdata[143:128];
    in_item.want_count = s_tdata[147:144];
  end

  assign s_tready = (fill != 2'(gocu_pkg::QDEPTH));
  assign push = s_tvalid && s_tready;
  assign q_valid = (fill != 2'd0);
  assign q_item = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= 2'd0;
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (q_pop) rd_ptr <= ~rd_ptr;
      fill <= fill + 2'(push) - 2'(q_pop);
    end
  end
endmodule
`default_nettype wire

// ===== hdl/gocu_back.sv =====
// Back end: group lookup, row load, evict and sorted insert, write back and listing.
// Holds the row memory and the output register. Depends on gocu_pkg.
`timescale 1ns / 1ps
`default_nettype none
module gocu_back (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic [gocu_pkg::LIM_W-1:0] keep_limit,
  input  wire logic q_valid,
  input  wire gocu_pkg::item_t q_item,
  output logic q_pop,
  output logic m_tvalid,
  input  wire logic m_tready,
  output logic [gocu_pkg::OUT_W-1:0] m_tdata,
  output logic m_tlast
);
  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_MATCH  = 9'b000000010,
    S_SEL    = 9'b000000100,
    S_LOAD   = 9'b000001000,
    S_EVICT  = 9'b000010000,
    S_INSERT = 9'b000100000,
    S_STORE  = 9'b001000000,
    S_LIST   = 9'b010000000,
    S_RESULT = 9'b100000000
  } state_t;

  localparam int CW = gocu_pkg::CNT_W;
  localparam int GW = gocu_pkg::GRP_W;
  localparam int RW = gocu_pkg::ROW_W;
  localparam int NG = gocu_pkg::GROUPS;
  localparam int NR = gocu_pkg::ROWS;

  state_t state;
  gocu_pkg::item_t item;

  logic [NG-1:0] group_valid;
  logic [gocu_pkg::KEY_W-1:0] key_store [NG];
  logic [CW-1:0] count_store [NG];
  gocu_pkg::row_t mem [NG*NR];
  gocu_pkg::row_t rdata;

  logic [NG-1:0] hit_vec;
  logic [NG-1:0] free_vec;
  logic [GW-1:0] hit_g;
  logic [GW-1:0] free_g;
  logic [GW-1:0] grp;
  logic [CW-1:0] cnt;
  logic [CW-1:0] idx;
  logic [CW-1:0] list_n;
  logic [RW-1:0] rd_idx;
  logic rd_pend;
  gocu_pkg::row_t rows [NR];
  gocu_pkg::row_t ins_rows [NR];
  logic [CW-1:0] pos;
  logic [CW-1:0] lim;
  logic [CW-1:0] want_n;
  logic [CW-1:0] top_idx;
  logic ev;
  logic [gocu_pkg::HND_W-1:0] evh;
  logic out_free;
  logic [gocu_pkg::OUT_W-1:0] res_data;

  assign out_free = !m_tvalid || m_tready;
  assign q_pop = (state == S_IDLE) && q_valid;

  // Lowest matching and lowest free group.
  always_comb begin
    hit_g = '0;
    free_g = '0;
    for (int g = NG - 1; g >= 0; g--) begin
      if (hit_vec[g]) hit_g = GW'(g);
      if (free_vec[g]) free_g = GW'(g);
    end
  end

  // A limit of zero acts as one; above the group size it saturates.
  always_comb begin
    if (keep_limit == '0) lim = CW'(1);
    else if (CW'(keep_limit) > CW'(NR)) lim = CW'(NR);
    else lim = CW'(keep_limit);
    want_n = (CW'(item.want_count) > cnt) ? cnt : CW'(item.want_count);
    top_idx = cnt - CW'(1) - idx;
  end

  // Sorted insert: the new row goes after every stored row with an equal or lower key.
  always_comb begin
    pos = '0;
    for (int i = 0; i < NR; i++) begin
      if (CW'(i) < cnt && rows[i].order_key <= item.order_key) pos = pos + CW'(1);
    end
    for (int i = 0; i < NR; i++) begin
      if (CW'(i) < pos) ins_rows[i] = rows[i];
      else if (CW'(i) == pos) ins_rows[i] = '{item.order_key, item.row_handle};
      else ins_rows[i] = rows[(i > 0) ? i - 1 : 0];
    end
  end

  always_ff @(posedge clk) begin
    rd_pend <= (state == S_LOAD) && (idx < cnt);
    if (state == S_LOAD && idx < cnt) begin
      rdata <= mem[{grp, idx[RW-1:0]}];
      rd_idx <= idx[RW-1:0];
    end
    if (state == S_STORE) begin
      mem[{grp, idx[RW-1:0]}] <= rows[idx[RW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) item <= q_item;
    if (state == S_MATCH) begin
      for (int g = 0; g < NG; g++) begin
        hit_vec[g] <= group_valid[g] && (key_store[g] == item.grp_key);
      end
      free_vec <= ~group_valid;
    end
    if (state == S_SEL && !(|hit_vec) && !item.is_list && (|free_vec)) begin
      key_store[free_g] <= item.grp_key;
    end
    if (state == S_INSERT) count_store[grp] <= cnt + CW'(1);
    if (state == S_LOAD && rd_pend) rows[rd_idx] <= rdata;
    if (state == S_EVICT && cnt >= lim) begin
      for (int i = 0; i < NR - 1; i++) rows[i] <= rows[i + 1];
    end
    if (state == S_INSERT) begin
      for (int i = 0; i < NR; i++) rows[i] <= ins_rows[i];
    end
  end

  // Single-result items build their result in res_data; it reaches m_tdata only when
  // the output register is free, so a stalled result is never overwritten.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      group_valid <= '0;
      m_tvalid <= 1'b0;
      grp <= '0;
      cnt <= '0;
      idx <= '0;
      list_n <= '0;
      ev <= 1'b0;
      evh <= '0;
      res_data <= '0;
      m_tdata <= '0;
      m_tlast <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && state != S_LIST && state != S_RESULT) m_tvalid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (q_valid) state <= S_MATCH;
        end
        S_MATCH: state <= S_SEL;
        S_SEL: begin
          idx <= '0;
          ev <= 1'b0;
          evh <= '0;
          if (|hit_vec) begin
            grp <= hit_g;
            cnt <= count_store[hit_g];
            state <= S_LOAD;
          end else if (item.is_list) begin
            res_data <= {4'd0, 36'(gocu_pkg::ST_MISS)};
            state <= S_RESULT;
          end else if (|free_vec) begin
            group_valid[free_g] <= 1'b1;
            grp <= free_g;
            cnt <= '0;
            state <= S_LOAD;
          end else begin
            res_data <= {4'd0, 36'(gocu_pkg::ST_FULL)};
            state <= S_RESULT;
          end
        end
        S_LOAD: begin
          if (idx < cnt) begin
            idx <= idx + CW'(1);
          end else if (!rd_pend) begin
            idx <= '0;
            if (!item.is_list) begin
              state <= S_EVICT;
            end else if (want_n == '0) begin
              res_data <= {4'd0, 36'(gocu_pkg::ST_OK)};
              state <= S_RESULT;
            end else begin
              list_n <= want_n;
              state <= S_LIST;
            end
          end
        end
        S_EVICT: begin
          if (cnt >= lim) begin
            ev <= 1'b1;
            evh <= rows[0].handle;
            cnt <= cnt - CW'(1);
          end
          state <= S_INSERT;
        end
        S_INSERT: begin
          cnt <= cnt + CW'(1);
          state <= S_STORE;
        end
        S_STORE: begin
          idx <= idx + CW'(1);
          if (idx == cnt - CW'(1)) begin
            res_data <= {4'd0, evh, ev, 16'd0, 1'b0, gocu_pkg::ST_OK};
            state <= S_RESULT;
          end
        end
        S_LIST: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            m_tdata <= {4'd0, 16'd0, 1'b0, rows[top_idx[RW-1:0]].handle, 1'b1,
                        gocu_pkg::ST_OK};
            m_tlast <= (idx + CW'(1) == list_n);
            idx <= idx + CW'(1);
            if (idx + CW'(1) == list_n) state <= S_IDLE;
          end else begin
            m_tvalid <= 1'b1;
          end
        end
        S_RESULT: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            m_tdata <= res_data;
            m_tlast <= 1'b1;
            state <= S_IDLE;
          end else begin
            m_tvalid <= 1'b1;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== hdl/gocu_checker.sv =====
// Port-level checks for the grouped ordered row cache, bound to the top level.
// Depends on grouped_ordered_row_cache_unit.
`timescale 1ns / 1ps
`default_nettype none
module gocu_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic m_tvalid,
  input wire logic m_tready,
  input wire logic [39:0] m_tdata,
  input wire logic m_tlast
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result dropped while stalled");
  a_list_clean: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[2] |-> m_tdata[1:0] == 2'd0 && !m_tdata[19])
    else $error("listed row carries status or eviction");
  a_multi_list: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tlast |-> m_tdata[2])
    else $error("non-final result is not a listed row");
  a_evh_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[19] |-> m_tdata[35:20] == 16'd0)
    else $error("evicted handle set without eviction");
endmodule

bind grouped_ordered_row_cache_unit gocu_checker u_gocu_checker (
  .clk(clk),
  .rst(rst),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata(m_tdata),
  .m_tlast(m_tlast)
);
`default_nettype wire

// ===== dv/tb.sv =====
// Testbench for grouped_ordered_row_cache_unit: stream driver, result monitor and
// an in-bench model of the grouped row cache. Depends on gocu_pkg and the RTL.
`timescale 1ns / 1ps
`default_nettype none
module tb;
  import gocu_pkg::*;

  logic clk;
  logic rst;
  logic s_tvalid;
  logic s_tready;
  logic [IN_W-1:0] s_tdata;
  logic s_tuser;
  logic m_tvalid;
  logic m_tready;
  logic [OUT_W-1:0] m_tdata;
  logic m_tlast;
  logic psel;
  logic penable;
  logic pwrite;
  logic [2:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  localparam logic [2:0] ADDR_LIMIT = 3'd0;
  localparam int CYCLE_LIMIT = 400000;

  // One expected result transfer.
  typedef struct packed {
    logic [1:0] status;
    logic row_valid;
    logic [HND_W-1:0] row_out;
    logic evicted;
    logic [HND_W-1:0] evicted_handle;
    logic last;
  } result_t;

  grouped_ordered_row_cache_unit u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // Shadow of the cache contents, updated as items are accepted.
  logic [LIM_W-1:0] sh_limit;
  logic sh_valid [GROUPS];
  logic [KEY_W-1:0] sh_key [GROUPS];
  int sh_count [GROUPS];
  logic [KEY_W-1:0] sh_order [GROUPS][ROWS];
  logic [HND_W-1:0] sh_handle [GROUPS][ROWS];

  item_t pending_items[$];
  result_t expected_results[$];

  int errors;
  int cycle_count;
  int send_idle_pct;
  int recv_stall_pct;
  int hold_cycles;
  bit done;
  bit in_taken;

  function automatic int find_group(logic [KEY_W-1:0] key);
    for (int g = 0; g < GROUPS; g++)
      if (sh_valid[g] && sh_key[g] == key) return g;
    return -1;
  endfunction

  // Applies one accepted item to the shadow and queues the results it causes.
  function automatic void predict_item(item_t it);
    int g;
    int lim;
    int cnt;
    int pos;
    int n;
    result_t r;
    r = '0;
    r.last = 1'b1;
    g = find_group(it.grp_key);
    if (it.is_list == OP_CACHE) begin
      if (g < 0) begin
        for (g = 0; g < GROUPS; g++)
          if (!sh_valid[g]) break;
        if (g >= GROUPS) begin
          r.status = ST_FULL;
          expected_results.push_back(r);
          return;
        end
        sh_valid[g] = 1'b1;
        sh_key[g] = it.grp_key;
        sh_count[g] = 0;
      end
      lim = sh_limit;
      if (lim < 1) lim = 1;
      if (lim > ROWS) lim = ROWS;
      cnt = sh_count[g];
      if (cnt >= lim) begin
        // The row with the lowest order key leaves from the bottom of the sorted list.
        r.evicted = 1'b1;
        r.evicted_handle = sh_handle[g][0];
        for (int i = 1; i < cnt; i++) begin
          sh_order[g][i-1] = sh_order[g][i];
          sh_handle[g][i-1] = sh_handle[g][i];
        end
        cnt--;
      end
      pos = 0;
      while (pos < cnt && sh_order[g][pos] <= it.order_key) pos++;
      for (int i = cnt; i > pos; i--) begin
        sh_order[g][i] = sh_order[g][i-1];
        sh_handle[g][i] = sh_handle[g][i-1];
      end
      sh_order[g][pos] = it.order_key;
      sh_handle[g][pos] = it.row_handle;
      sh_count[g] = cnt + 1;
      expected_results.push_back(r);
    end else begin
      if (g < 0) begin
        r.status = ST_MISS;
        expected_results.push_back(r);
        return;
      end
      cnt = sh_count[g];
      n = it.want_count;
      if (n > cnt) n = cnt;
      if (n == 0) begin
        expected_results.push_back(r);
        return;
      end
      for (int k = 0; k < n; k++) begin
        r.row_valid = 1'b1;
        r.row_out = sh_handle[g][cnt-1-k];
        r.last = (k + 1 == n);
        expected_results.push_back(r);
      end
    end
  endfunction

  function automatic item_t make_item(logic op, logic [KEY_W-1:0] key,
                                      logic [KEY_W-1:0] order,
                                      logic [HND_W-1:0] hnd, logic [WANT_W-1:0] want);
    item_t it;
    it.is_list = op;
    it.grp_key = key;
    it.order_key = order;
    it.row_handle = hnd;
    it.want_count = want;
    return it;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Driver: offers the head of the pending queue, idling at random. A new item is
  // offered only once the previous one was taken at the rising edge.
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      in_taken = 1'b0;
    end else if (!s_tvalid || in_taken) begin
      in_taken = 1'b0;
      if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        s_tvalid <= 1'b1;
        s_tdata <= {4'b0, pending_items[0].want_count, pending_items[0].row_handle,
                    pending_items[0].order_key, pending_items[0].grp_key};
        s_tuser <= pending_items[0].is_list;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // The accepted item leaves the pending queue at the rising edge where it is
  // transferred, and its results are predicted there.
  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) begin
      predict_item(make_item(s_tuser, s_tdata[63:0], s_tdata[127:64],
                             s_tdata[143:128], s_tdata[147:144]));
      void'(pending_items.pop_front());
      in_taken = 1'b1;
    end
  end

  // Receiver stall pattern, with a long hold-off when requested.
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_cycles > 0) begin
      m_tready <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Monitor: compares every result transfer with the oldest expectation.
  always @(posedge clk) begin
    result_t exp_r;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result transfer %h", m_tdata);
        errors++;
      end else begin
        exp_r = expected_results.pop_front();
        if (m_tdata[1:0] !== exp_r.status) begin
          $error("status exp %0d got %0d", exp_r.status, m_tdata[1:0]);
          errors++;
        end
        if (m_tdata[2] !== exp_r.row_valid) begin
          $error("row_valid exp %0d got %0d", exp_r.row_valid, m_tdata[2]);
          errors++;
        end
        if (m_tdata[18:3] !== exp_r.row_out) begin
          $error("row_out exp %h got %h", exp_r.row_out, m_tdata[18:3]);
          errors++;
        end
        if (m_tdata[19] !== exp_r.evicted) begin
          $error("evicted exp %0d got %0d", exp_r.evicted, m_tdata[19]);
          errors++;
        end
        if (m_tdata[35:20] !== exp_r.evicted_handle) begin
          $error("evicted_handle exp %h got %h", exp_r.evicted_handle, m_tdata[35:20]);
          errors++;
        end
        if (m_tlast !== exp_r.last) begin
          $error("last exp %0d got %0d", exp_r.last, m_tlast);
          errors++;
        end
      end
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT && !done) begin
      $display("grouped_ordered_row_cache_unit verification failed");
      $finish;
    end
  end

  task automatic wait_drained();
    while (pending_items.size() != 0 || s_tvalid || expected_results.size() != 0)
      @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_limit(logic [LIM_W-1:0] val);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_LIMIT;
    pwdata <= {28'b0, val};
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    sh_limit = val;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Random mix: mostly caches into a few hot keys, with lists and misses.
  task automatic queue_random(int count, int nkeys);
    logic [KEY_W-1:0] key;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(9) == 0) key = rand64();
      else key = 64'hA5A5_0000_0000_0000 ^ 64'($urandom_range(nkeys - 1));
      if ($urandom_range(2) == 0)
        pending_items.push_back(make_item(OP_LIST, key, rand64(), 16'($urandom()),
                                          4'($urandom_range(15))));
      else
        pending_items.push_back(make_item(OP_CACHE, key,
                                          ($urandom_range(3) == 0) ? rand64() :
                                          64'($urandom_range(7)),
                                          16'($urandom()), 4'($urandom())));
    end
  endtask

  initial begin
    errors = 0;
    cycle_count = 0;
    done = 1'b0;
    hold_cycles = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = 1'b0;
    m_tready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    sh_limit = 4'd2;
    for (int g = 0; g < GROUPS; g++) begin
      sh_valid[g] = 1'b0;
      sh_count[g] = 0;
    end
    rst = 1'b1;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed: missing group, empty list, extremes of keys, equal order keys,
    // eviction at the reset limit, oversize want_count.
    pending_items.push_back(make_item(OP_LIST, '1, '0, '0, 4'd8));
    pending_items.push_back(make_item(OP_CACHE, '0, '1, 16'hFFFF, 4'hF));
    pending_items.push_back(make_item(OP_CACHE, '0, '0, 16'h0000, 4'h0));
    pending_items.push_back(make_item(OP_CACHE, '0, '0, 16'h1234, 4'h0));
    pending_items.push_back(make_item(OP_LIST, '0, '0, '0, 4'd0));
    pending_items.push_back(make_item(OP_LIST, '0, '0, '0, 4'hF));
    pending_items.push_back(make_item(OP_CACHE, '1, 64'd5, 16'hAAAA, 4'h0));
    pending_items.push_back(make_item(OP_LIST, '1, '0, '0, 4'd1));
    wait_drained();

    // Limit of 8 with a full walk, then lowered to show single eviction.
    write_limit(4'd8);
    for (int i = 0; i < 10; i++)
      pending_items.push_back(make_item(OP_CACHE, 64'h77, 64'(9 - i), 16'(i), 4'h0));
    pending_items.push_back(make_item(OP_LIST, 64'h77, '0, '0, 4'd8));
    wait_drained();
    write_limit(4'd3);
    pending_items.push_back(make_item(OP_CACHE, 64'h77, 64'd100, 16'h5555, 4'h0));
    pending_items.push_back(make_item(OP_LIST, 64'h77, '0, '0, 4'd15));
    // Fill the group table so a new key is dropped.
    for (int g = 0; g < GROUPS; g++)
      pending_items.push_back(make_item(OP_CACHE, 64'h1000 + g, 64'd1, 16'(g), 4'h0));
    wait_drained();

    // Fresh keys cannot be created any more, so reuse keys 0x1000 to 0x100F; only 0x1000 to 0x100C are held.
    write_limit(4'd0);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_cycles = 300;
    for (int i = 0; i < 36; i++)
      pending_items.push_back(make_item(1'($urandom_range(1)),
                                        64'h1000 + 64'($urandom_range(15)),
                                        rand64(), 16'($urandom()), 4'($urandom())));
    wait_drained();

    write_limit(4'd15);
    send_idle_pct = 51;
    queue_random(36, 20);
    wait_drained();
    write_limit(4'd1);
    send_idle_pct = 0;
    recv_stall_pct = 51;
    queue_random(36, 20);
    wait_drained();
    write_limit(4'd5);
    send_idle_pct = 8;
    recv_stall_pct = 8;
    queue_random(36, 20);
    wait_drained();

    done = 1'b1;
    if (errors == 0)
      $display("grouped_ordered_row_cache_unit verification clean");
    else
      $display("grouped_ordered_row_cache_unit verification failed");
    $finish;
  end
endmodule
`default_nettype wire

// ===== files.f =====
hdl/gocu_pkg.sv
hdl/gocu_front.sv
hdl/gocu_back.sv
hdl/grouped_ordered_row_cache_unit.sv
hdl/gocu_checker.sv
dv/tb.sv
